// ===== rtl/tcl_pkg.sv =====
// Shared types, codes and constants of the table character lexer.
package tcl_pkg;

    // Default width of the line counter
    localparam int LINE_BITS_DEF = 16;

    // Width of the line number carried in each result
    localparam int LINE_OUT_BITS = 16;

    // Output queue depth and pointer widths
    localparam int OQ_DEPTH     = 4;
    localparam int OQ_PTR_BITS  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_BITS  = $clog2(OQ_DEPTH + 1);

    // Configuration register indexes
    localparam logic [2:0] REG_LINE_END    = 3'd0;
    localparam logic [2:0] REG_OPERAND     = 3'd1;
    localparam logic [2:0] REG_INSTR       = 3'd2;
    localparam logic [2:0] REG_OPEN        = 3'd3;
    localparam logic [2:0] REG_CLOSE       = 3'd4;

    // Configuration reset values
    localparam logic [7:0] RST_LINE_END    = 8'd59;
    localparam logic [7:0] RST_OPERAND     = 8'd44;
    localparam logic [7:0] RST_INSTR       = 8'd58;
    localparam logic [7:0] RST_OPEN        = 8'd91;
    localparam logic [7:0] RST_CLOSE       = 8'd93;

    // Fixed characters
    localparam logic [7:0] CH_UNDERSCORE   = 8'h5F;
    localparam logic [7:0] CH_MINUS        = 8'h2D;
    localparam logic [7:0] CH_GREATER      = 8'h3E;
    localparam logic [7:0] CH_PERCENT      = 8'h25;
    localparam logic [7:0] CH_SLASH        = 8'h2F;
    localparam logic [7:0] CH_STAR         = 8'h2A;
    localparam logic [7:0] CH_SPACE        = 8'h20;
    localparam logic [7:0] CH_TAB          = 8'h09;
    localparam logic [7:0] CH_NEWLINE      = 8'h0A;
    localparam logic [7:0] CH_NUL          = 8'h00;

    // Token classes
    typedef enum logic [3:0] {
        CLS_LETTER   = 4'd0,
        CLS_DIGIT    = 4'd1,
        CLS_LINETERM = 4'd2,
        CLS_OPERAND  = 4'd3,
        CLS_INSTR    = 4'd4,
        CLS_ARROW    = 4'd5,
        CLS_OPEN     = 4'd6,
        CLS_CLOSE    = 4'd7,
        CLS_SPACE    = 4'd8,
        CLS_PERCENT  = 4'd9,
        CLS_END      = 4'd10,
        CLS_OTHER    = 4'd11
    } cls_t;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_MINUS   = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_STAR    = 3'd4
    } mode_t;

    // Configurable punctuation characters
    typedef struct packed {
        logic [7:0] line_end_char;
        logic [7:0] operand_split_char;
        logic [7:0] instr_split_char;
        logic [7:0] open_char;
        logic [7:0] close_char;
    } cfg_t;

    // One result item
    typedef struct packed {
        cls_t                     token_class;
        logic [7:0]               token_char;
        logic [LINE_OUT_BITS-1:0] line_number;
        logic                     comment_error;
        logic                     last_of_run;
    } tok_t;

endpackage

// ===== rtl/tcl_class.sv =====
// Character classifier: maps one byte to its token class.
module tcl_class (
    input  logic [7:0]   chr,
    input  tcl_pkg::cfg_t cfg,
    output tcl_pkg::cls_t cls
);

    logic is_letter;
    logic is_digit;

    assign is_letter = (chr >= 8'h41 && chr <= 8'h5A) || (chr >= 8'h61 && chr <= 8'h7A)
                       || (chr == tcl_pkg::CH_UNDERSCORE);
    assign is_digit  = (chr >= 8'h30 && chr <= 8'h39);

    // Priority: letters, digits, registers in order, then fixed classes
    always_comb begin
        if (is_letter) begin
            cls = tcl_pkg::CLS_LETTER;
        end else if (is_digit) begin
            cls = tcl_pkg::CLS_DIGIT;
        end else if (chr == cfg.line_end_char) begin
            cls = tcl_pkg::CLS_LINETERM;
        end else if (chr == cfg.operand_split_char) begin
            cls = tcl_pkg::CLS_OPERAND;
        end else if (chr == cfg.instr_split_char) begin
            cls = tcl_pkg::CLS_INSTR;
        end else if (chr == cfg.open_char) begin
            cls = tcl_pkg::CLS_OPEN;
        end else if (chr == cfg.close_char) begin
            cls = tcl_pkg::CLS_CLOSE;
        end else if (chr == tcl_pkg::CH_SPACE || chr == tcl_pkg::CH_TAB
                     || chr == tcl_pkg::CH_NEWLINE) begin
            cls = tcl_pkg::CLS_SPACE;
        end else if (chr == tcl_pkg::CH_PERCENT) begin
            cls = tcl_pkg::CLS_PERCENT;
        end else begin
            cls = tcl_pkg::CLS_OTHER;
        end
    end

endmodule

// ===== rtl/tcl_scan.sv =====
// Scanner: mode and line state, turns one character into up to two tokens.
module tcl_scan #(
    parameter int LINE_BITS = tcl_pkg::LINE_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  logic [7:0]    in_char,
    input  logic          end_of_input,
    input  tcl_pkg::cfg_t cfg,
    output tcl_pkg::tok_t push_tok [2],
    output logic [1:0]    push_n
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    tcl_pkg::mode_t       mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic                 pend_reg, pend_next;
    logic [LINE_BITS-1:0] cstart_reg, cstart_next;

    tcl_pkg::cls_t        char_cls;
    tcl_pkg::cls_t        slash_cls;
    logic [LINE_BITS-1:0] line_inc;
    logic [LINE_BITS-1:0] line_scan;

    logic                 held_v;
    tcl_pkg::cls_t        held_cls;
    logic [7:0]           held_char;
    logic                 scan;
    logic                 tok_v;
    tcl_pkg::cls_t        tok_cls;
    logic [7:0]           tok_char;
    logic [LINE_BITS-1:0] tok_line;
    logic                 tok_err;
    tcl_pkg::tok_t        held_tok;
    tcl_pkg::tok_t        main_tok;

    tcl_class u_class_char (
        .chr (in_char),
        .cfg (cfg),
        .cls (char_cls)
    );

    tcl_class u_class_slash (
        .chr (tcl_pkg::CH_SLASH),
        .cfg (cfg),
        .cls (slash_cls)
    );

    // Saturating line increment
    assign line_inc  = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_ONE;
    assign line_scan = pend_reg ? line_inc : line_reg;

    // Next state and tokens of the current item
    always_comb begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        pend_next   = pend_reg;
        cstart_next = cstart_reg;
        held_v      = 1'b0;
        held_cls    = tcl_pkg::CLS_OTHER;
        held_char   = tcl_pkg::CH_SLASH;
        scan        = 1'b1;
        tok_v       = 1'b0;
        tok_cls     = tcl_pkg::CLS_OTHER;
        tok_char    = in_char;
        tok_line    = line_reg;
        tok_err     = 1'b0;

        case (mode_reg)
            tcl_pkg::MODE_SLASH: begin
                if (!end_of_input && in_char == tcl_pkg::CH_STAR) begin
                    cstart_next = line_reg;
                    mode_next   = tcl_pkg::MODE_COMMENT;
                    scan        = 1'b0;
                end else begin
                    held_v    = 1'b1;
                    held_cls  = slash_cls;
                    held_char = tcl_pkg::CH_SLASH;
                    mode_next = tcl_pkg::MODE_NORMAL;
                end
            end
            tcl_pkg::MODE_MINUS: begin
                mode_next = tcl_pkg::MODE_NORMAL;
                if (!end_of_input && in_char == tcl_pkg::CH_GREATER) begin
                    tok_v    = 1'b1;
                    tok_cls  = tcl_pkg::CLS_ARROW;
                    tok_char = tcl_pkg::CH_MINUS;
                    scan     = 1'b0;
                end else begin
                    held_v    = 1'b1;
                    held_cls  = tcl_pkg::CLS_OTHER;
                    held_char = tcl_pkg::CH_MINUS;
                end
            end
            tcl_pkg::MODE_COMMENT, tcl_pkg::MODE_STAR: begin
                scan = 1'b0;
                if (end_of_input) begin
                    tok_v     = 1'b1;
                    tok_cls   = tcl_pkg::CLS_END;
                    tok_char  = tcl_pkg::CH_NUL;
                    tok_line  = cstart_reg;
                    tok_err   = 1'b1;
                    mode_next = tcl_pkg::MODE_NORMAL;
                end else if (mode_reg == tcl_pkg::MODE_COMMENT) begin
                    if (in_char == tcl_pkg::CH_STAR) begin
                        mode_next = tcl_pkg::MODE_STAR;
                    end else if (in_char == tcl_pkg::CH_NEWLINE) begin
                        line_next = line_inc;
                    end
                end else begin
                    if (in_char == tcl_pkg::CH_SLASH) begin
                        mode_next = tcl_pkg::MODE_NORMAL;
                    end else begin
                        if (in_char == tcl_pkg::CH_NEWLINE) begin
                            line_next = line_inc;
                        end
                        mode_next = tcl_pkg::MODE_COMMENT;
                    end
                end
            end
            default: begin
                mode_next = tcl_pkg::MODE_NORMAL;
            end
        endcase

        // Scan the character itself in normal mode, or after a held '/' or '-'
        if (scan) begin
            line_next = line_scan;
            pend_next = 1'b0;
            tok_line  = line_scan;
            if (end_of_input) begin
                tok_v    = 1'b1;
                tok_cls  = tcl_pkg::CLS_END;
                tok_char = tcl_pkg::CH_NUL;
            end else if (in_char == tcl_pkg::CH_SLASH) begin
                mode_next = tcl_pkg::MODE_SLASH;
            end else if (char_cls == tcl_pkg::CLS_OTHER && in_char == tcl_pkg::CH_MINUS) begin
                mode_next = tcl_pkg::MODE_MINUS;
            end else begin
                tok_v   = 1'b1;
                tok_cls = char_cls;
                if (char_cls == tcl_pkg::CLS_SPACE && in_char == tcl_pkg::CH_NEWLINE) begin
                    pend_next = 1'b1;
                end
            end
        end
    end

    // Pack the held and main tokens into queue order
    always_comb begin
        logic [LINE_BITS+tcl_pkg::LINE_OUT_BITS-1:0] held_ext;
        logic [LINE_BITS+tcl_pkg::LINE_OUT_BITS-1:0] main_ext;
        held_ext = {{tcl_pkg::LINE_OUT_BITS{1'b0}}, line_reg};
        main_ext = {{tcl_pkg::LINE_OUT_BITS{1'b0}}, tok_line};

        held_tok.token_class   = held_cls;
        held_tok.token_char    = held_char;
        held_tok.line_number   = held_ext[tcl_pkg::LINE_OUT_BITS-1:0];
        held_tok.comment_error = 1'b0;
        held_tok.last_of_run   = !tok_v;

        main_tok.token_class   = tok_cls;
        main_tok.token_char    = tok_char;
        main_tok.line_number   = main_ext[tcl_pkg::LINE_OUT_BITS-1:0];
        main_tok.comment_error = tok_err;
        main_tok.last_of_run   = 1'b1;

        push_tok[0] = held_v ? held_tok : main_tok;
        push_tok[1] = main_tok;
        push_n      = fire ? ({1'b0, held_v} + {1'b0, tok_v}) : 2'd0;
    end

    // Advance state on each processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= tcl_pkg::MODE_NORMAL;
            line_reg   <= LINE_ONE;
            pend_reg   <= 1'b0;
            cstart_reg <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            pend_reg   <= pend_next;
            cstart_reg <= cstart_next;
        end
    end

endmodule

// ===== rtl/tcl_outq.sv =====
// Result queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high.
module tcl_outq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tcl_pkg::tok_t                     push_tok [2],
    input  logic [1:0]                        push_n,
    output logic                              space_ok,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tcl_pkg::tok_t                     out_tok
);

    tcl_pkg::tok_t                   mem_reg [tcl_pkg::OQ_DEPTH];
    logic [tcl_pkg::OQ_PTR_BITS-1:0] head_reg, head_next;
    logic [tcl_pkg::OQ_PTR_BITS-1:0] tail_reg, tail_next;
    logic [tcl_pkg::OQ_CNT_BITS-1:0] count_reg, count_next;
    logic [tcl_pkg::OQ_PTR_BITS-1:0] tail_plus1;
    logic                            pop;

    localparam logic [tcl_pkg::OQ_CNT_BITS-1:0] ROOM_LIMIT =
        tcl_pkg::OQ_CNT_BITS'(tcl_pkg::OQ_DEPTH - 2);

    // Room for two more tokens, judged from registered count only
    assign space_ok   = (count_reg <= ROOM_LIMIT);
    assign out_valid  = (count_reg != '0);
    assign out_tok    = mem_reg[head_reg];
    assign pop        = out_valid && out_ready;
    assign tail_plus1 = tail_reg + tcl_pkg::OQ_PTR_BITS'(1);

    always_comb begin
        head_next  = head_reg + tcl_pkg::OQ_PTR_BITS'(pop);
        tail_next  = tail_reg + tcl_pkg::OQ_PTR_BITS'(push_n);
        count_next = count_reg + tcl_pkg::OQ_CNT_BITS'(push_n)
                     - tcl_pkg::OQ_CNT_BITS'(pop);
    end

    // Store pushed tokens
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[tail_reg] <= push_tok[0];
        end
        if (push_n == 2'd2) begin
            mem_reg[tail_plus1] <= push_tok[1];
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/table_char_lexer.sv =====
// Top level of the table character lexer: input register, scanner, result queue.
//
// Input channel (s_): one item per character; s_tdata carries the byte and
// s_tlast marks end of input (the byte is then ignored). Result channel (m_):
// one token per item, with tdata holding class, character and line number,
// tuser the unterminated-comment flag and tlast the final token of an item.
// An item gives zero, one or two tokens: comment text and a held '/' or '-'
// give none, a held '/' or '-' that is not continued goes out before the
// next token.
// Path: an accepted item is registered in the input register, scanned from
// there once the result queue has room, and its tokens are written into the
// queue that drives m_. Throughput: one item per cycle while the queue has
// room; the four-entry result queue takes items while it has room for two
// tokens, so items that each give two tokens are bounded by the m_ side.
// Reset (aresetn low, synchronous) empties the queue, returns to normal mode,
// sets the line count to one and loads the default punctuation characters.
// When the receiver stalls, tokens wait in the queue and s_tready drops once
// the queue holds three or more tokens and the input register is occupied;
// nothing is lost.
// Configuration writes (cfg_wr_en) take effect at once; write only while idle.
module table_char_lexer #(
    parameter int LINE_BITS = tcl_pkg::LINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] token_class, [11:4] token_char,
                                   // [27:12] line_number, [31:28] zero
    output logic        m_tuser,   // comment_error
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    tcl_pkg::cfg_t cfg_reg;
    logic          in_valid_reg;
    logic [7:0]    in_char_reg;
    logic          in_eof_reg;
    logic          fire;
    logic          space_ok;
    tcl_pkg::tok_t push_tok [2];
    logic [1:0]    push_n;
    tcl_pkg::tok_t out_tok;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_end_char      <= tcl_pkg::RST_LINE_END;
            cfg_reg.operand_split_char <= tcl_pkg::RST_OPERAND;
            cfg_reg.instr_split_char   <= tcl_pkg::RST_INSTR;
            cfg_reg.open_char          <= tcl_pkg::RST_OPEN;
            cfg_reg.close_char         <= tcl_pkg::RST_CLOSE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tcl_pkg::REG_LINE_END: cfg_reg.line_end_char      <= cfg_wdata;
                tcl_pkg::REG_OPERAND:  cfg_reg.operand_split_char <= cfg_wdata;
                tcl_pkg::REG_INSTR:    cfg_reg.instr_split_char   <= cfg_wdata;
                tcl_pkg::REG_OPEN:     cfg_reg.open_char          <= cfg_wdata;
                tcl_pkg::REG_CLOSE:    cfg_reg.close_char         <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register: process when the queue has room
    assign fire     = in_valid_reg && space_ok;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_eof_reg  <= s_tlast;
        end
    end

    tcl_scan #(
        .LINE_BITS (LINE_BITS)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .in_char      (in_char_reg),
        .end_of_input (in_eof_reg),
        .cfg          (cfg_reg),
        .push_tok     (push_tok),
        .push_n       (push_n)
    );

    tcl_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_tok  (push_tok),
        .push_n    (push_n),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    // Pack the result item
    assign m_tdata = {4'b0000, out_tok.line_number, out_tok.token_char,
                      4'(out_tok.token_class)};
    assign m_tuser = out_tok.comment_error;
    assign m_tlast = out_tok.last_of_run;

endmodule
